@@ hdl/aes_ofb_packet_cipher_iv_shuffle_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packet cipher block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AES_OFB_PACKET_CIPHER_IV_SHUFFLE_MACROS_SVH
`define AES_OFB_PACKET_CIPHER_IV_SHUFFLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AOPC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AOPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/aopc_pkg.sv @@
// ----------------------------------------------------------------------------
// aopc_pkg
// Types, constants, tables and datapath functions of the packet cipher.
// ----------------------------------------------------------------------------
package aopc_pkg;

    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_SEED   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_IV = 1'b1;

    localparam logic [10:0] FIRST_CHUNK_LEN     = 11'd1456;
    localparam logic [10:0] FIRST_CHUNK_LEN_BIG = 11'd1452;
    localparam logic [10:0] CHUNK_LEN           = 11'd1460;

    localparam logic [31:0] SHUFFLE_SEED = 32'hC650_53F2;

    localparam logic [3:0] AES_ROUNDS = 4'd14;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_USE,
        KIND_CHAIN,
        KIND_RESTART
    } kind_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [3:0]  idx;
        kind_t       kind;
        logic [31:0] iv;
    } entry_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SHUF [256] = '{
        8'hEC,8'h3F,8'h77,8'hA4,8'h45,8'hD0,8'h71,8'hBF,
        8'hB7,8'h98,8'h20,8'hFC,8'h4B,8'hE9,8'hB3,8'hE1,
        8'h5C,8'h22,8'hF7,8'h0C,8'h44,8'h1B,8'h81,8'hBD,
        8'h63,8'h8D,8'hD4,8'hC3,8'hF2,8'h10,8'h19,8'hE0,
        8'hFB,8'hA1,8'h6E,8'h66,8'hEA,8'hAE,8'hD6,8'hCE,
        8'h06,8'h18,8'h4E,8'hEB,8'h78,8'h95,8'hDB,8'hBA,
        8'hB6,8'h42,8'h7A,8'h2A,8'h83,8'h0B,8'h54,8'h67,
        8'h6D,8'hE8,8'h65,8'hE7,8'h2F,8'h07,8'hF3,8'hAA,
        8'h27,8'h7B,8'h85,8'hB0,8'h26,8'hFD,8'h8B,8'hA9,
        8'hFA,8'hBE,8'hA8,8'hD7,8'hCB,8'hCC,8'h92,8'hDA,
        8'hF9,8'h93,8'h60,8'h2D,8'hDD,8'hD2,8'hA2,8'h9B,
        8'h39,8'h5F,8'h82,8'h21,8'h4C,8'h69,8'hF8,8'h31,
        8'h87,8'hEE,8'h8E,8'hAD,8'h8C,8'h6A,8'hBC,8'hB5,
        8'h6B,8'h59,8'h13,8'hF1,8'h04,8'h00,8'hF6,8'h5A,
        8'h35,8'h79,8'h48,8'h8F,8'h15,8'hCD,8'h97,8'h57,
        8'h12,8'h3E,8'h37,8'hFF,8'h9D,8'h4F,8'h51,8'hF5,
        8'hA3,8'h70,8'hBB,8'h14,8'h75,8'hC2,8'hB8,8'h72,
        8'hC0,8'hED,8'h7D,8'h68,8'hC9,8'h2E,8'h0D,8'h62,
        8'h46,8'h17,8'h11,8'h4D,8'h6C,8'hC4,8'h7E,8'h53,
        8'hC1,8'h25,8'hC7,8'h9A,8'h1C,8'h88,8'h58,8'h2C,
        8'h89,8'hDC,8'h02,8'h64,8'h40,8'h01,8'h5D,8'h38,
        8'hA5,8'hE2,8'hAF,8'h55,8'hD5,8'hEF,8'h1A,8'h7C,
        8'hA7,8'h5B,8'hA6,8'h6F,8'h86,8'h9F,8'h73,8'hE6,
        8'h0A,8'hDE,8'h2B,8'h99,8'h4A,8'h47,8'h9C,8'hDF,
        8'h09,8'h76,8'h9E,8'h30,8'h0E,8'hE4,8'hB2,8'h94,
        8'hA0,8'h3B,8'h34,8'h1D,8'h28,8'h0F,8'h36,8'hE3,
        8'h23,8'hB4,8'h03,8'hD8,8'h90,8'hC8,8'h3C,8'hFE,
        8'h5E,8'h32,8'h24,8'h50,8'h1F,8'h3A,8'h43,8'h8A,
        8'h96,8'h41,8'h74,8'hAC,8'h52,8'h33,8'hF0,8'hD9,
        8'h29,8'h80,8'hB1,8'h16,8'hD3,8'hAB,8'h91,8'hB9,
        8'h84,8'h7F,8'h61,8'h1E,8'hCF,8'hC5,8'hD1,8'h56,
        8'h3D,8'hCA,8'hF4,8'h05,8'hC6,8'hE5,8'h08,8'h49
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    // One IV shuffle step: fold byte v into the four shuffle bytes s.
    function automatic logic [31:0] shuffle_step(input logic [7:0] v, input logic [31:0] s);
        logic [7:0]  tv;
        logic [7:0]  n0;
        logic [7:0]  n1;
        logic [7:0]  n2;
        logic [7:0]  n3;
        logic [31:0] w;
        tv = SHUF[v];
        n0 = s[7:0] + (SHUF[s[15:8]] - v);
        n1 = s[15:8] - (s[23:16] ^ tv);
        n2 = s[23:16] ^ (SHUF[s[31:24]] + v);
        n3 = s[31:24] - (n0 - tv);
        w  = {n3, n2, n1, n0};
        return {w[28:0], w[31:29]};
    endfunction

    // SubBytes, ShiftRows and (unless final) MixColumns; byte i at bits 8i+7..8i.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
        logic [7:0]   sub [16];
        logic [127:0] sh;
        logic [127:0] mc;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   all;
        logic [1:0]   src_col;
        for (int i = 0; i < 16; i++) begin
            sub[i] = SBOX[s[8*i +: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                src_col = 2'(c + j);
                sh[8*(j + 4*c) +: 8] = sub[j + 4*int'(src_col)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = sh[32*c      +: 8];
            a1  = sh[32*c + 8  +: 8];
            a2  = sh[32*c + 16 +: 8];
            a3  = sh[32*c + 24 +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mc[32*c      +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            mc[32*c + 8  +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            mc[32*c + 16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            mc[32*c + 24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return final_rnd ? sh : mc;
    endfunction

    // Next four key-schedule words from the previous two round keys.
    function automatic logic [127:0] key_next(input logic [127:0] ka, input logic [127:0] kb,
                                              input logic rot, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        if (rot) begin
            t = {SBOX[kb[103:96]], SBOX[kb[127:120]], SBOX[kb[119:112]],
                 SBOX[kb[111:104]] ^ rc};
        end
        else begin
            t = {SBOX[kb[127:120]], SBOX[kb[119:112]], SBOX[kb[111:104]],
                 SBOX[kb[103:96]]};
        end
        w0 = ka[31:0]   ^ t;
        w1 = ka[63:32]  ^ w0;
        w2 = ka[95:64]  ^ w1;
        w3 = ka[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

endpackage

@@ hdl/aopc_front.sv @@
// ----------------------------------------------------------------------------
// aopc_front
// Accepts payload bytes, tracks the chunk position and the IV, and tags each
// byte with the keystream work it needs. Runs the IV shuffle at packet end.
// ----------------------------------------------------------------------------
module aopc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             is_last,
    input  logic             big_packet,
    input  logic             iv_load,
    input  logic [31:0]      iv_value,
    output logic             push,
    output aopc_pkg::entry_t push_entry,
    input  logic             q_full
);

    logic [10:0] pos_reg;
    logic [10:0] pos_next;
    logic        first_reg;
    logic        first_next;
    logic [31:0] iv_reg;
    logic [31:0] iv_next;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [31:0] shuf_reg;
    logic [31:0] shuf_next;
    logic [31:0] shuf_step;
    logic [10:0] pos_inc;
    logic [10:0] limit;
    logic        accept;

    assign in_stall = busy_reg || q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept;

    always_comb
    begin
        push_entry.data = data_byte;
        push_entry.last = is_last;
        push_entry.idx  = pos_reg[3:0];
        push_entry.iv   = iv_reg;
        if (pos_reg == '0) begin
            push_entry.kind = aopc_pkg::KIND_RESTART;
        end
        else if (pos_reg[3:0] == '0) begin
            push_entry.kind = aopc_pkg::KIND_CHAIN;
        end
        else begin
            push_entry.kind = aopc_pkg::KIND_USE;
        end
    end

    assign shuf_step = aopc_pkg::shuffle_step(iv_reg[8*step_reg +: 8], shuf_reg);

    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        iv_next    = iv_reg;
        busy_next  = busy_reg;
        step_next  = step_reg;
        shuf_next  = shuf_reg;
        pos_inc    = pos_reg + 11'd1;
        if (!first_reg) begin
            limit = aopc_pkg::CHUNK_LEN;
        end
        else if (big_packet) begin
            limit = aopc_pkg::FIRST_CHUNK_LEN_BIG;
        end
        else begin
            limit = aopc_pkg::FIRST_CHUNK_LEN;
        end

        if (busy_reg) begin
            shuf_next = shuf_step;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                iv_next   = shuf_step;
                busy_next = 1'b0;
            end
        end

        if (accept) begin
            pos_next = pos_inc;
            if (pos_inc >= limit) begin
                pos_next   = '0;
                first_next = 1'b0;
            end
            if (is_last) begin
                pos_next   = '0;
                first_next = 1'b1;
                busy_next  = 1'b1;
                step_next  = '0;
                shuf_next  = aopc_pkg::SHUFFLE_SEED;
            end
        end

        if (iv_load) begin
            iv_next    = iv_value;
            pos_next   = '0;
            first_next = 1'b1;
            busy_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
            iv_reg    <= '0;
            busy_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            iv_reg    <= iv_next;
            busy_reg  <= busy_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shuf_reg <= shuf_next;
    end

endmodule

@@ hdl/aopc_queue.sv @@
// ----------------------------------------------------------------------------
// aopc_queue
// Short in-order queue of tagged bytes between the front and the back.
// ----------------------------------------------------------------------------
module aopc_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aopc_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output aopc_pkg::entry_t head
);

    aopc_pkg::entry_t                   mem_reg [aopc_pkg::QUEUE_DEPTH];
    logic [aopc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [aopc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [aopc_pkg::QUEUE_PTR_W:0]     count_reg;
    logic [aopc_pkg::QUEUE_PTR_W:0]     count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full       = (count_reg == (aopc_pkg::QUEUE_PTR_W+1)'(aopc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/aopc_back.sv @@
// ----------------------------------------------------------------------------
// aopc_back
// Produces keystream blocks with a round-per-cycle AES-256 core and on-the-fly
// key expansion, and XORs each queued byte into the output register.
// ----------------------------------------------------------------------------
`include "aes_ofb_packet_cipher_iv_shuffle_macros.svh"

module aopc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      key_seed,
    input  logic             head_valid,
    input  aopc_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_AES = 2'b10
    } state_t;

    state_t       fsm_reg;
    state_t       fsm_next;
    logic [127:0] blk_reg;
    logic [127:0] ka_reg;
    logic [127:0] kb_reg;
    logic [7:0]   rc_reg;
    logic [3:0]   round_reg;
    logic [127:0] ks_reg;
    logic         ks_fresh_reg;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;
    logic [255:0] key;
    logic [127:0] src;
    logic [127:0] round_out;
    logic [127:0] key_gen;
    logic         out_free;
    logic         start;
    logic         emit;
    logic         last_round;

    always_comb
    begin
        key = '0;
        for (int i = 0; i < 8; i++) begin
            key[32*i +: 8] = key_seed[8*i +: 8];
        end
    end

    assign src        = (head.kind == aopc_pkg::KIND_RESTART) ? {4{head.iv}} : ks_reg;
    assign last_round = (round_reg == aopc_pkg::AES_ROUNDS);
    assign round_out  = aopc_pkg::aes_round(blk_reg, last_round) ^ kb_reg;
    assign key_gen    = aopc_pkg::key_next(ka_reg, kb_reg, round_reg[0], rc_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        start    = 1'b0;
        emit     = 1'b0;
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_RUN:
            begin
                if (head_valid) begin
                    if (head.kind == aopc_pkg::KIND_USE || ks_fresh_reg) begin
                        emit = out_free;
                    end
                    else begin
                        start    = 1'b1;
                        fsm_next = S_AES;
                    end
                end
            end
            S_AES:
            begin
                if (last_round) begin
                    fsm_next = S_RUN;
                end
            end
            default:
            begin
                fsm_next = S_RUN;
            end
        endcase
    end

    assign pop = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fsm_reg       <= S_RUN;
            round_reg     <= '0;
            ks_fresh_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            fsm_reg <= fsm_next;
            if (start) begin
                round_reg <= 4'd1;
            end
            else if (fsm_reg == S_AES) begin
                round_reg <= last_round ? '0 : round_reg + 4'd1;
            end
            if (fsm_reg == S_AES && last_round) begin
                ks_fresh_reg <= 1'b1;
            end
            else if (emit) begin
                ks_fresh_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            blk_reg <= src ^ key[127:0];
            ka_reg  <= key[127:0];
            kb_reg  <= key[255:128];
            rc_reg  <= 8'h01;
        end
        else if (fsm_reg == S_AES) begin
            blk_reg <= round_out;
            ka_reg  <= kb_reg;
            kb_reg  <= key_gen;
            if (round_reg[0]) begin
                rc_reg <= aopc_pkg::xtime(rc_reg);
            end
            if (last_round) begin
                ks_reg <= round_out;
            end
        end
        if (emit) begin
            out_byte_reg <= head.data ^ ks_reg[8*head.idx +: 8];
            out_last_reg <= head.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    `AOPC_ASSERT_IMPLY(a_no_pop_during_aes, fsm_reg == S_AES, !pop, "pop while AES busy")
    `AOPC_ASSERT_IMPLY(a_round_in_range, fsm_reg == S_AES, (round_reg != 4'd0) && (round_reg <= aopc_pkg::AES_ROUNDS), "AES round out of range")
    `AOPC_ASSERT_NEXT(a_block_ready_after_aes, fsm_reg == S_AES && last_round, ks_fresh_reg && fsm_reg == S_RUN, "keystream block not marked ready")

endmodule

@@ hdl/aes_ofb_packet_cipher_iv_shuffle.sv @@
// ----------------------------------------------------------------------------
// aes_ofb_packet_cipher_iv_shuffle
// Packet payload cipher: AES-256 output-feedback keystream with shuffled IV.
// ----------------------------------------------------------------------------
// Each payload byte comes out XORed with one keystream byte, one result
// transaction per input transaction, in order. A byte that falls inside an
// already computed 16-byte keystream block needs no AES work, so runs of
// such bytes stream at one per cycle while out_stall is low. A byte at the
// start of a block (chunk start, or every 16th byte) waits for the iterative
// AES-256 core: one load step plus fourteen rounds, with the key schedule
// expanded alongside the rounds. After the last byte of a packet the input
// side stalls while the IV shuffle steps through the four old IV bytes, one
// byte per cycle. A four-entry queue sits between the input side and the AES
// side, and the output is a register, so the input keeps taking bytes while
// a result waits downstream, as long as the queue has room.
// Register 0 is key_seed, register 1 is initial_iv; writing initial_iv also
// starts a fresh packet. Configuration must be written only while idle.
// ----------------------------------------------------------------------------
module aes_ofb_packet_cipher_iv_shuffle
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        big_packet,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic             [63:0] key_seed_reg;
    logic                    iv_load;
    logic                    push;
    logic                    q_full;
    logic                    pop;
    logic                    head_valid;
    aopc_pkg::entry_t        push_entry;
    aopc_pkg::entry_t        head;

    // The key register is read by the AES core at the start of every block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_seed_reg <= '0;
        end
        else if (wr_en && wr_index == aopc_pkg::REG_KEY_SEED) begin
            key_seed_reg <= wr_data;
        end
    end

    assign iv_load = wr_en && (wr_index == aopc_pkg::REG_INITIAL_IV);

    aopc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .big_packet (big_packet),
        .iv_load    (iv_load),
        .iv_value   (wr_data[31:0]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    aopc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    aopc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_seed   (key_seed_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule
